// ----- rtl/core/source_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer checker.
// No dependencies.
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH
// Property that must hold on every clock unless reset is high.
`define ST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked during reset as well.
`define ST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ----- rtl/core/stok_pkg.sv -----
// Shared types, token codes and classification functions for the tokenizer.
// No dependencies.
package stok_pkg;

  localparam int PositionBitsDefault = 32;
  localparam int QueueDepthDefault = 4;
  localparam int KindBits = 7;

  typedef enum logic [2:0] {
    M_IDLE, M_NUMBER, M_STRING, M_IDENT, M_SYMBOL, M_LINE_COM, M_BLOCK_COM, M_BLOCK_STAR
  } lex_mode_t;

  localparam logic [6:0] K_EOF = 7'd0, K_NUMBER = 7'd1, K_STRING = 7'd2, K_IDENT = 7'd3,
    K_KW_BASE = 7'd4,
    K_LPAREN = 7'd33, K_RPAREN = 7'd34, K_LBRACE = 7'd35, K_RBRACE = 7'd36,
    K_LBRACKET = 7'd37, K_RBRACKET = 7'd38, K_SEMI = 7'd39, K_COLON = 7'd40,
    K_COMMA = 7'd41, K_DOT = 7'd42, K_PLUSPLUS = 7'd43, K_PLUSEQ = 7'd44, K_PLUS = 7'd45,
    K_MINUSMINUS = 7'd46, K_MINUSEQ = 7'd47, K_ARROW = 7'd48, K_MINUS = 7'd49,
    K_STAREQ = 7'd50, K_STAR = 7'd51, K_SLASHEQ = 7'd52, K_SLASH = 7'd53,
    K_PERCENTEQ = 7'd54, K_PERCENT = 7'd55, K_EQEQ = 7'd56, K_FATARROW = 7'd57,
    K_EQ = 7'd58, K_NE = 7'd59, K_NOT = 7'd60, K_LE = 7'd61, K_SHL = 7'd62, K_LT = 7'd63,
    K_GE = 7'd64, K_SHR = 7'd65, K_GT = 7'd66, K_ANDAND = 7'd67, K_BITAND = 7'd68,
    K_OROR = 7'd69, K_BITOR = 7'd70, K_XOR = 7'd71, K_BITNOT = 7'd72,
    K_QUESTION = 7'd73, K_UNKNOWN = 7'd74;

  localparam int NumKeywords = 29;

  // Keywords packed big-endian into the low bytes, with their lengths.
  function automatic logic [63:0] kw_text(input int i);
    logic [63:0] t;
    case (i)
      0: t = 64'h666e;               1: t = 64'h6c6574;
      2: t = 64'h6d7574;             3: t = 64'h6966;
      4: t = 64'h656c7365;           5: t = 64'h7768696c65;
      6: t = 64'h666f72;             7: t = 64'h72657475726e;
      8: t = 64'h737472756374;       9: t = 64'h656e756d;
      10: t = 64'h756e696f6e;        11: t = 64'h65787465726e;
      12: t = 64'h74727565;          13: t = 64'h66616c7365;
      14: t = 64'h6e756c6c;          15: t = 64'h61736d;
      16: t = 64'h766f6c6174696c65;  17: t = 64'h6938;
      18: t = 64'h693136;            19: t = 64'h693332;
      20: t = 64'h693634;            21: t = 64'h7538;
      22: t = 64'h753136;            23: t = 64'h753332;
      24: t = 64'h753634;            25: t = 64'h663332;
      26: t = 64'h663634;            27: t = 64'h626f6f6c;
      default: t = 64'h766f6964;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    logic [3:0] l;
    case (i)
      0, 3, 17, 21: l = 4'd2;
      4, 9, 12, 14, 27, 28: l = 4'd4;
      5, 10, 13: l = 4'd5;
      7, 8, 11: l = 4'd6;
      16: l = 4'd8;
      default: l = 4'd3;
    endcase
    return l;
  endfunction

  // Keyword lookup on the packed prefix; wlen is the saturated length (0..9).
  function automatic logic [6:0] word_kind(input logic [63:0] w, input logic [3:0] wlen);
    logic [6:0] k;
    k = K_IDENT;
    for (int i = 0; i < NumKeywords; i++) begin
      if (wlen == kw_len(i) && w == kw_text(i)) k = K_KW_BASE + 7'(i);
    end
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic has_pair(input logic [7:0] c);
    logic r;
    case (c)
      ":", "+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] k;
    case (c)
      "(": k = K_LPAREN;   ")": k = K_RPAREN;
      "{": k = K_LBRACE;   "}": k = K_RBRACE;
      "[": k = K_LBRACKET; "]": k = K_RBRACKET;
      ";": k = K_SEMI;     ":": k = K_COLON;
      ",": k = K_COMMA;    ".": k = K_DOT;
      "+": k = K_PLUS;     "-": k = K_MINUS;
      "*": k = K_STAR;     "/": k = K_SLASH;
      "%": k = K_PERCENT;  "=": k = K_EQ;
      "!": k = K_NOT;      "<": k = K_LT;
      ">": k = K_GT;       "&": k = K_BITAND;
      "|": k = K_BITOR;    "^": k = K_XOR;
      "~": k = K_BITNOT;   "?": k = K_QUESTION;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Two-character symbol kind, K_EOF when the pair does not form one.
  function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
    logic [6:0] k;
    k = K_EOF;
    case (p)
      ":": if (c == ":") k = K_COLON;
      "+": if (c == "+") k = K_PLUSPLUS; else if (c == "=") k = K_PLUSEQ;
      "-": if (c == "-") k = K_MINUSMINUS; else if (c == "=") k = K_MINUSEQ;
           else if (c == ">") k = K_ARROW;
      "*": if (c == "=") k = K_STAREQ;
      "/": if (c == "=") k = K_SLASHEQ;
      "%": if (c == "=") k = K_PERCENTEQ;
      "=": if (c == "=") k = K_EQEQ; else if (c == ">") k = K_FATARROW;
      "!": if (c == "=") k = K_NE;
      "<": if (c == "=") k = K_LE; else if (c == "<") k = K_SHL;
      ">": if (c == "=") k = K_GE; else if (c == ">") k = K_SHR;
      "&": if (c == "&") k = K_ANDAND;
      "|": if (c == "|") k = K_OROR;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/stok_front.sv -----
// Front end: scanner state machine, position counters, token classification.
// Depends on stok_pkg. Produces up to two token records per byte.
module stok_front import stok_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [7:0]                source_byte,
  input  logic                      end_of_input,
  output logic                      emit_a,
  output logic                      emit_b,
  output logic [6:0]                kind_a,
  output logic [PositionBits-1:0]   start_a,
  output logic [PositionBits-1:0]   len_a,
  output logic [PositionBits-1:0]   line_a,
  output logic [PositionBits-1:0]   col_a,
  output logic [6:0]                kind_b,
  output logic [PositionBits-1:0]   start_b,
  output logic [PositionBits-1:0]   len_b,
  output logic [PositionBits-1:0]   line_b,
  output logic [PositionBits-1:0]   col_b
);

  localparam logic [PositionBits-1:0] PosMax = '1;
  localparam logic [PositionBits-1:0] PosOne = PositionBits'(1);

  lex_mode_t               mode, mode_next;
  logic [7:0]              pending_symbol, pending_symbol_next;
  logic [PositionBits-1:0] token_start, token_start_next;
  logic [PositionBits-1:0] byte_offset, line_count, column_count;
  logic [PositionBits-1:0] byte_offset_next, line_count_next, column_count_next;
  logic [63:0]             word_prefix, word_prefix_next;
  logic [3:0]              word_length, word_length_next;
  logic                    escape_pending, escape_pending_next;

  // Counter values after this byte is consumed
  logic [PositionBits-1:0] off_adv, line_adv, col_adv;
  logic                    nl;
  logic [6:0]              wkind, pkind;
  logic                    start_new;

  always_comb begin
    nl = source_byte == 8'h0a;
    off_adv = (byte_offset != PosMax) ? byte_offset + PosOne : byte_offset;
    line_adv = (nl && line_count != PosMax) ? line_count + PosOne : line_count;
    col_adv = nl ? PosOne : ((column_count != PosMax) ? column_count + PosOne : column_count);
    wkind = word_kind(word_prefix, word_length);
    pkind = pair_kind(pending_symbol, source_byte);
  end

  always_comb begin
    mode_next = mode;
    pending_symbol_next = pending_symbol;
    token_start_next = token_start;
    byte_offset_next = byte_offset;
    line_count_next = line_count;
    column_count_next = column_count;
    word_prefix_next = word_prefix;
    word_length_next = word_length;
    escape_pending_next = escape_pending;
    emit_a = 1'b0;
    emit_b = 1'b0;
    kind_a = K_EOF;
    start_a = token_start;
    len_a = byte_offset - token_start;
    line_a = line_count;
    col_a = column_count;
    kind_b = K_EOF;
    start_b = byte_offset;
    len_b = '0;
    line_b = line_count;
    col_b = column_count;
    start_new = 1'b0;
    if (in_valid) begin
      if (end_of_input) begin
        // flush the open token, then EOF
        unique case (mode)
          M_NUMBER: begin emit_a = 1'b1; kind_a = K_NUMBER; end
          M_IDENT:  begin emit_a = 1'b1; kind_a = wkind; end
          M_STRING: begin emit_a = 1'b1; kind_a = K_STRING; end
          M_SYMBOL: begin emit_a = 1'b1; kind_a = single_kind(pending_symbol); end
          default: ;
        endcase
        emit_b = 1'b1;
        mode_next = M_IDLE;
        escape_pending_next = 1'b0;
      end else begin
        byte_offset_next = off_adv;
        line_count_next = line_adv;
        column_count_next = col_adv;
        unique case (mode)
          M_NUMBER: begin
            if (!(is_digit(source_byte) || source_byte == ".")) begin
              emit_a = 1'b1; kind_a = K_NUMBER; start_new = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_alpha(source_byte) || is_digit(source_byte) || source_byte == "_") begin
              if (word_length < 4'd8) word_prefix_next = {word_prefix[55:0], source_byte};
              if (word_length < 4'd9) word_length_next = word_length + 4'd1;
            end else begin
              emit_a = 1'b1; kind_a = wkind; start_new = 1'b1;
            end
          end
          M_STRING: begin
            if (escape_pending) escape_pending_next = 1'b0;
            else if (source_byte == "\\") escape_pending_next = 1'b1;
            else if (source_byte == "\"") begin
              emit_a = 1'b1; kind_a = K_STRING;
              line_a = line_adv; col_a = col_adv;
              mode_next = M_IDLE;
            end
          end
          M_LINE_COM: begin
            if (nl) start_new = 1'b1;
          end
          M_BLOCK_COM: begin
            if (source_byte == "*") mode_next = M_BLOCK_STAR;
          end
          M_BLOCK_STAR: begin
            if (source_byte == "/") mode_next = M_IDLE;
            else if (source_byte != "*") mode_next = M_BLOCK_COM;
          end
          M_SYMBOL: begin
            if (pending_symbol == "/" && source_byte == "/") mode_next = M_LINE_COM;
            else if (pending_symbol == "/" && source_byte == "*") mode_next = M_BLOCK_COM;
            else if (pkind != K_EOF) begin
              emit_a = 1'b1; kind_a = pkind; len_a = off_adv - token_start;
              line_a = line_adv; col_a = col_adv;
              mode_next = M_IDLE;
            end else begin
              emit_a = 1'b1; kind_a = single_kind(pending_symbol); start_new = 1'b1;
            end
          end
          default: start_new = 1'b1;
        endcase
        // byte opens something new
        if (start_new) begin
          mode_next = M_IDLE;
          if (is_space(source_byte)) begin
          end else if (is_digit(source_byte)) begin
            token_start_next = byte_offset; mode_next = M_NUMBER;
          end else if (source_byte == "\"") begin
            token_start_next = off_adv; escape_pending_next = 1'b0; mode_next = M_STRING;
          end else if (is_alpha(source_byte) || source_byte == "_") begin
            token_start_next = byte_offset;
            word_prefix_next = {56'd0, source_byte};
            word_length_next = 4'd1;
            mode_next = M_IDENT;
          end else if (has_pair(source_byte)) begin
            token_start_next = byte_offset; pending_symbol_next = source_byte;
            mode_next = M_SYMBOL;
          end else begin
            token_start_next = byte_offset;
            emit_b = 1'b1; kind_b = single_kind(source_byte);
            start_b = byte_offset; len_b = off_adv - byte_offset;
            line_b = line_adv; col_b = col_adv;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pending_symbol <= '0;
      token_start <= '0;
      byte_offset <= '0;
      line_count <= PosOne;
      column_count <= PosOne;
      word_prefix <= '0;
      word_length <= '0;
      escape_pending <= 1'b0;
    end else begin
      mode <= mode_next;
      pending_symbol <= pending_symbol_next;
      token_start <= token_start_next;
      byte_offset <= byte_offset_next;
      line_count <= line_count_next;
      column_count <= column_count_next;
      word_prefix <= word_prefix_next;
      word_length <= word_length_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ----- rtl/core/stok_queue.sv -----
// Token queue between scanner and result port: takes up to two items a cycle.
// Depends on stok_pkg.
module stok_queue import stok_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_a,
  input  logic [Width-1:0] data_a,
  input  logic             wr_b,
  input  logic [Width-1:0] data_b,
  input  logic             rd,
  output logic [Width-1:0] rd_data,
  output logic             is_empty,
  output logic             room_two
);

  localparam int AddrBits = $clog2(Depth);

  logic [Width-1:0]  mem [Depth];
  logic [AddrBits-1:0] wp, rp;
  logic [AddrBits:0]   count;
  logic [AddrBits-1:0] wp1;
  logic [AddrBits:0]   n_wr;

  assign wp1 = wp + AddrBits'(1);
  assign n_wr = (AddrBits+1)'(wr_a) + (AddrBits+1)'(wr_b);
  assign is_empty = count == '0;
  assign room_two = count <= (AddrBits+1)'(Depth - 2);
  assign rd_data = mem[rp];

  // Storage: a-slot first when both are written
  always_ff @(posedge clk) begin
    if (wr_a) mem[wp] <= data_a;
    if (wr_b) mem[wr_a ? wp1 : wp] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + n_wr[AddrBits-1:0];
      if (rd) rp <= rp + AddrBits'(1);
      count <= count + n_wr - (AddrBits+1)'(rd);
    end
  end

endmodule

// ----- rtl/core/source_tokenizer.sv -----
// Source tokenizer top level: scanner front end feeding a token queue.
// Depends on stok_pkg, stok_front and stok_queue.
//
// Usage: source bytes enter on the push/full queue port, one item per cycle,
// with end_of_input marking the end of the source (no byte carried). Tokens
// leave on the empty/pop queue port, oldest first; run_last marks the final
// token caused by one input item. Each byte may yield zero, one or two
// tokens; an end marker yields the pending token, if any, and then EOF.
// A token is visible in the cycle after the item that completes it.
// Throughput: one byte per cycle while the token queue has room for two
// entries; full rises when fewer than two slots remain, so a stalled
// receiver backs up into the source and nothing is lost.
// Reset (synchronous) clears the queue, the scanner state and counters:
// offset 0, line 1, column 1.
module source_tokenizer import stok_pkg::*; #(
  parameter int PositionBits = PositionBitsDefault,
  parameter int QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte,
  input  logic        end_of_input,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [31:0] text_length,
  output logic [31:0] line_after,
  output logic [31:0] column_after,
  output logic        run_last
);

  localparam int RecBits = KindBits + 1 + 4 * 32;

  logic accept, room_two, q_empty;
  logic emit_a, emit_b;
  logic [6:0] kind_a, kind_b;
  logic [PositionBits-1:0] start_a, len_a, line_a, col_a;
  logic [PositionBits-1:0] start_b, len_b, line_b, col_b;
  logic [RecBits-1:0] rec_a, rec_b, rec_out;
  logic [31:0] sa, la, na, ca, sb, lb, nb, cb;

  assign full = !room_two;
  assign accept = push && room_two;

  stok_front #(.PositionBits(PositionBits)) u_front (
    .clk, .rst, .in_valid(accept), .source_byte, .end_of_input,
    .emit_a, .emit_b,
    .kind_a, .start_a, .len_a, .line_a, .col_a,
    .kind_b, .start_b, .len_b, .line_b, .col_b
  );

  // Widen or trim positions to the 32-bit result fields
  always_comb begin
    sa = 32'(start_a); la = 32'(len_a); na = 32'(line_a); ca = 32'(col_a);
    sb = 32'(start_b); lb = 32'(len_b); nb = 32'(line_b); cb = 32'(col_b);
    rec_a = {kind_a, sa, la, na, ca, !emit_b};
    rec_b = {kind_b, sb, lb, nb, cb, 1'b1};
  end

  stok_queue #(.Width(RecBits), .Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_a(emit_a), .data_a(rec_a),
    .wr_b(emit_b), .data_b(rec_b),
    .rd(pop && !q_empty),
    .rd_data(rec_out),
    .is_empty(q_empty),
    .room_two
  );

  assign empty = q_empty;
  assign {token_kind, start_offset, text_length, line_after, column_after, run_last} = rec_out;

endmodule

// ----- rtl/core/stok_checker.sv -----
// Port-level checker for the source tokenizer, bound to the top level.
// Depends on source_tokenizer_defines.svh and stok_pkg.
`include "source_tokenizer_defines.svh"
module stok_checker import stok_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       end_of_input,
  input logic       empty,
  input logic [6:0] token_kind,
  input logic       run_last
);
  // Queue is empty right after reset
  `ST_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> empty, "queue not empty after reset")
  // An accepted end marker always yields a token next cycle
  `ST_ASSERT(a_eof_out, (push && !full && end_of_input) |=> !empty, "no token after end")
  // EOF is always the last token of its item
  `ST_ASSERT(a_eof_last, (!empty && token_kind == K_EOF) |-> run_last, "EOF not last")
  // Token kinds stay in the code range
  `ST_ASSERT(a_kind_range, !empty |-> token_kind <= K_UNKNOWN, "token kind out of range")
endmodule

bind source_tokenizer stok_checker u_stok_checker (
  .clk, .rst, .push, .full, .end_of_input, .empty, .token_kind, .run_last
);

// ----- tb/sv/tb.sv -----
// Self-checking testbench for source_tokenizer: byte items in, token items out.
// Depends on stok_pkg (token codes, mode type) and the source_tokenizer RTL.
module tb import stok_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  source_byte = 8'd0;
  logic        end_of_input = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, run_last;
  logic [6:0]  token_kind;
  logic [31:0] start_offset, text_length, line_after, column_after;

  source_tokenizer dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .source_byte(source_byte), .end_of_input(end_of_input),
    .empty(empty), .pop(pop), .token_kind(token_kind),
    .start_offset(start_offset), .text_length(text_length),
    .line_after(line_after), .column_after(column_after), .run_last(run_last)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] line;
    logic [31:0] col;
    logic        last;
  } token_t;

  localparam logic [31:0] PosMax = 32'hFFFF_FFFF;
  localparam int WatchdogLimit = 20000;

  token_t    token_q[$];
  int        errors = 0;
  int        quiet_cycles = 0;
  bit        idle_push = 1'b1;
  bit        idle_pop = 1'b1;
  bit        hold_pop = 1'b0;

  // Scanner model state
  lex_mode_t   sc_mode;
  logic [7:0]  sc_sym;
  logic [31:0] sc_start, sc_off, sc_line, sc_col;
  logic [63:0] sc_word;
  logic [31:0] sc_wlen;
  bit          sc_esc;
  int          made;

  // Keywords, in token-code order starting at K_KW_BASE
  string keywords[29] = '{"fn", "let", "mut", "if", "else", "while", "for", "return",
    "struct", "enum", "union", "extern", "true", "false", "null", "asm", "volatile",
    "i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64", "f32", "f64", "bool", "void"};

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == PosMax) ? v : v + 32'd1;
  endfunction

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit pairable(logic [7:0] c);
    return c == ":" || c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
           c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|";
  endfunction

  function automatic logic [6:0] lone_kind(logic [7:0] c);
    case (c)
      "(": return K_LPAREN;   ")": return K_RPAREN;
      "{": return K_LBRACE;   "}": return K_RBRACE;
      "[": return K_LBRACKET; "]": return K_RBRACKET;
      ";": return K_SEMI;     ":": return K_COLON;
      ",": return K_COMMA;    ".": return K_DOT;
      "+": return K_PLUS;     "-": return K_MINUS;
      "*": return K_STAR;     "/": return K_SLASH;
      "%": return K_PERCENT;  "=": return K_EQ;
      "!": return K_NOT;      "<": return K_LT;
      ">": return K_GT;       "&": return K_BITAND;
      "|": return K_BITOR;    "^": return K_XOR;
      "~": return K_BITNOT;   "?": return K_QUESTION;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [6:0] duo_kind(logic [7:0] p, logic [7:0] c);
    case (p)
      ":": return (c == ":") ? K_COLON : K_EOF;
      "+": return (c == "+") ? K_PLUSPLUS : (c == "=") ? K_PLUSEQ : K_EOF;
      "-": return (c == "-") ? K_MINUSMINUS : (c == "=") ? K_MINUSEQ :
                  (c == ">") ? K_ARROW : K_EOF;
      "*": return (c == "=") ? K_STAREQ : K_EOF;
      "/": return (c == "=") ? K_SLASHEQ : K_EOF;
      "%": return (c == "=") ? K_PERCENTEQ : K_EOF;
      "=": return (c == "=") ? K_EQEQ : (c == ">") ? K_FATARROW : K_EOF;
      "!": return (c == "=") ? K_NE : K_EOF;
      "<": return (c == "=") ? K_LE : (c == "<") ? K_SHL : K_EOF;
      ">": return (c == "=") ? K_GE : (c == ">") ? K_SHR : K_EOF;
      "&": return (c == "&") ? K_ANDAND : K_EOF;
      "|": return (c == "|") ? K_OROR : K_EOF;
      default: return K_EOF;
    endcase
  endfunction

  function automatic logic [6:0] ident_kind();
    logic [63:0] packed_kw;
    for (int i = 0; i < 29; i++) begin
      packed_kw = 64'd0;
      for (int j = 0; j < keywords[i].len(); j++)
        packed_kw = (packed_kw << 8) | 64'(keywords[i][j]);
      if (sc_wlen == 32'(keywords[i].len()) && sc_word == packed_kw)
        return K_KW_BASE + 7'(i);
    end
    return K_IDENT;
  endfunction

  task automatic scan_reset();
    sc_mode = M_IDLE; sc_sym = 8'd0; sc_start = 0; sc_off = 0;
    sc_line = 1; sc_col = 1; sc_word = 0; sc_wlen = 0; sc_esc = 1'b0;
  endtask

  task automatic step_pos(logic [7:0] c);
    sc_off = sat_up(sc_off);
    if (c == 8'h0A) begin
      sc_line = sat_up(sc_line);
      sc_col = 1;
    end else begin
      sc_col = sat_up(sc_col);
    end
  endtask

  task automatic add_token(logic [6:0] k, logic [31:0] s, logic [31:0] l);
    token_t t;
    t = '{k, s, l, sc_line, sc_col, 1'b0};
    token_q = {token_q, t};
    made++;
  endtask

  task automatic mark_last();
    token_t t;
    if (made > 0) begin
      t = token_q[$];
      t.last = 1'b1;
      token_q[$] = t;
    end
  endtask

  // Predict the tokens caused by one accepted item; appends to token_q
  task automatic scan_item(logic [7:0] c, bit eoi);
    logic [6:0] k;
    logic [31:0] str_len;
    made = 0;
    if (eoi) begin
      case (sc_mode)
        M_NUMBER: add_token(K_NUMBER, sc_start, sc_off - sc_start);
        M_IDENT:  add_token(ident_kind(), sc_start, sc_off - sc_start);
        M_STRING: add_token(K_STRING, sc_start, sc_off - sc_start);
        M_SYMBOL: add_token(lone_kind(sc_sym), sc_start, sc_off - sc_start);
        default: ;
      endcase
      add_token(K_EOF, sc_off, 0);
      sc_mode = M_IDLE;
      sc_esc = 1'b0;
      mark_last();
      return;
    end
    case (sc_mode)
      M_NUMBER: begin
        if (digit_c(c) || c == ".") begin
          step_pos(c);
          return;
        end
        add_token(K_NUMBER, sc_start, sc_off - sc_start);
      end
      M_IDENT: begin
        if (alpha_c(c) || digit_c(c) || c == "_") begin
          if (sc_wlen < 8) sc_word = (sc_word << 8) | 64'(c);
          if (sc_wlen != PosMax) sc_wlen++;
          step_pos(c);
          return;
        end
        add_token(ident_kind(), sc_start, sc_off - sc_start);
      end
      M_STRING: begin
        if (sc_esc) begin
          sc_esc = 1'b0;
        end else if (c == "\\") begin
          sc_esc = 1'b1;
        end else if (c == "\"") begin
          // text length excludes the closing quote
          str_len = sc_off - sc_start;
          step_pos(c);
          add_token(K_STRING, sc_start, str_len);
          sc_mode = M_IDLE;
          mark_last();
          return;
        end
        step_pos(c);
        return;
      end
      M_LINE_COM: begin
        if (c != 8'h0A) begin
          step_pos(c);
          return;
        end
      end
      M_BLOCK_COM: begin
        if (c == "*") sc_mode = M_BLOCK_STAR;
        step_pos(c);
        return;
      end
      M_BLOCK_STAR: begin
        if (c == "/") sc_mode = M_IDLE;
        else if (c != "*") sc_mode = M_BLOCK_COM;
        step_pos(c);
        return;
      end
      M_SYMBOL: begin
        if (sc_sym == "/" && (c == "/" || c == "*")) begin
          sc_mode = (c == "/") ? M_LINE_COM : M_BLOCK_COM;
          step_pos(c);
          return;
        end
        k = duo_kind(sc_sym, c);
        if (k != K_EOF) begin
          step_pos(c);
          add_token(k, sc_start, sc_off - sc_start);
          sc_mode = M_IDLE;
          mark_last();
          return;
        end
        add_token(lone_kind(sc_sym), sc_start, sc_off - sc_start);
      end
      default: ;
    endcase
    sc_mode = M_IDLE;
    // Token start from idle
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      step_pos(c);
    end else if (digit_c(c)) begin
      sc_start = sc_off; sc_mode = M_NUMBER; step_pos(c);
    end else if (c == "\"") begin
      step_pos(c); sc_start = sc_off; sc_esc = 1'b0; sc_mode = M_STRING;
    end else if (alpha_c(c) || c == "_") begin
      sc_start = sc_off; sc_word = 64'(c); sc_wlen = 1; sc_mode = M_IDENT; step_pos(c);
    end else if (pairable(c)) begin
      sc_start = sc_off; sc_sym = c; sc_mode = M_SYMBOL; step_pos(c);
    end else begin
      sc_start = sc_off; step_pos(c);
      add_token(lone_kind(c), sc_start, sc_off - sc_start);
    end
    mark_last();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Push one item, waiting for the handshake; predict its tokens on acceptance.
  // push stays high into the next item; it drops only while idling.
  task automatic send_item(logic [7:0] c, bit eoi);
    while (idle_push && $urandom_range(99) < 20) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    source_byte <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (full) @(posedge clk);
    scan_item(c, eoi);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Receiver: random pops, with an optional long hold-off
  always @(posedge clk) begin
    if (rst || hold_pop) pop <= 1'b0;
    else pop <= !(idle_pop && $urandom_range(99) < 20);
  end

  // Token checker, compares against the oldest prediction
  always @(posedge clk) begin
    token_t want;
    if (!rst && pop && !empty) begin
      if (token_q.size() == 0) begin
        report_mismatch("unexpected token kind", 32'(token_kind), 32'(K_EOF));
      end else begin
        want = token_q.pop_front();
        if (token_kind !== want.kind) report_mismatch("kind", 32'(token_kind), 32'(want.kind));
        if (start_offset !== want.start) report_mismatch("start", start_offset, want.start);
        if (text_length !== want.len) report_mismatch("length", text_length, want.len);
        if (line_after !== want.line) report_mismatch("line", line_after, want.line);
        if (column_after !== want.col) report_mismatch("column", column_after, want.col);
        if (run_last !== want.last) report_mismatch("run_last", 32'(run_last), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Random byte drawn mostly from source-like characters
  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "abcfnuvilotrsemw_019.\"\\/*:+-=<>!&|%(){}[];,^~? \n\t";
    case ($urandom_range(9))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(8'h80, 8'hFF));
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  task automatic send_random_piece();
    case ($urandom_range(9))
      0: send_text(keywords[$urandom_range(28)]);
      1: send_text({"\"", string'(8'($urandom_range("a", "z"))), "\\\"x\""});
      2: send_text("/* c * d **/");
      3: send_text("// note\n");
      4: send_text("12.5 ");
      5: send_item(8'd0, 1'b0);
      6: send_item(8'($urandom_range(255)), 1'b1);
      default: send_item(pick_byte(), 1'b0);
    endcase
  endtask

  initial begin
    // Directed rows: byte, end flag; tokens come from the scanner model
    typedef struct { logic [7:0] b; bit e; } row_t;
    row_t rows[$];
    token_t t0;
    int sent;
    string dir_text;
    scan_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // End marker right after reset: EOF at offset 0, line 1, column 1
    send_item(8'hFF, 1'b1);
    t0 = token_q[$];
    if (t0 != token_t'{K_EOF, 32'd0, 32'd0, 32'd1, 32'd1, 1'b1})
      report_mismatch("reset EOF", 32'(t0.kind), 32'(K_EOF));
    // NUL and high byte are one-byte unknown tokens
    send_item(8'h00, 1'b0);
    if (token_q[$].kind != K_UNKNOWN)
      report_mismatch("NUL kind", 32'(token_q[$].kind), 32'(K_UNKNOWN));
    send_item(8'hFF, 1'b0);
    dir_text = "a::b ==> fn volatile voids 3.1.4 x->y <<= //c\n/*q*/\"s\\\"t\\";
    for (int i = 0; i < dir_text.len(); i++)
      rows = {rows, row_t'{dir_text[i], 1'b0}};
    rows = {rows, row_t'{8'h00, 1'b1}};
    rows = {rows, row_t'{8'h00, 1'b1}};
    foreach (rows[i]) send_item(rows[i].b, rows[i].e);
    send_text("/* open"); send_item(8'h00, 1'b1);
    // NUL inside a string is ordinary text
    send_text("\"x"); send_item(8'h00, 1'b0); send_text("y\"");
    send_text("9&");  send_item(8'h00, 1'b1);

    // Random part with a no-idle stretch and a long receiver hold-off
    sent = 0;
    while (sent < 500) begin
      if (sent == 150) begin idle_push = 1'b0; idle_pop = 1'b0; end
      if (sent == 250) begin idle_push = 1'b1; idle_pop = 1'b1; end
      if (sent == 300) begin
        hold_pop = 1'b1;
        fork
          begin repeat (300) @(posedge clk); hold_pop = 1'b0; end
        join_none
      end
      send_random_piece();
      sent++;
    end
    send_item(8'h00, 1'b1);
    push <= 1'b0;

    while (token_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- source_tokenizer.f -----
+incdir+rtl/core
rtl/core/stok_pkg.sv
rtl/core/stok_front.sv
rtl/core/stok_queue.sv
rtl/core/source_tokenizer.sv
rtl/core/stok_checker.sv
tb/sv/tb.sv
